/* design/cbm_pkg.sv */
// Package for the cartridge bank mapper: request and result types,
// request type codes, write decode constants and the bank state record.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package cbm_pkg;

  // Request type codes.
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_CHR   = 2'd1;
  localparam logic [1:0] REQ_PRG   = 2'd2;

  // CPU write decode: the address is masked and then compared.
  localparam logic [15:0] DECODE_MASK     = 16'hF0C3;
  localparam logic [15:0] ADDR_PRG_FIRST  = 16'h8000;
  localparam logic [15:0] ADDR_MIRROR     = 16'h9000;
  localparam logic [15:0] ADDR_SWAP_A     = 16'h9002;
  localparam logic [15:0] ADDR_SWAP_B     = 16'h9080;
  localparam logic [15:0] ADDR_PRG_SECOND = 16'hA000;
  localparam logic [3:0]  CHR_PAGE_FIRST  = 4'hB;
  localparam logic [3:0]  CHR_PAGE_LAST   = 4'hE;

  // The last PRG bank register comes out of reset at its top value.
  localparam logic [7:0] LAST_BANK_RESET = 8'hFF;

  localparam int CHR_BANKS = 8;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [21:0] rom_address;
    logic [1:0]  mirror_mode;
  } result_t;

  // Every bank register of the mapper, as seen by the translator.
  typedef struct packed {
    logic [7:0]                      last_prg_bank;
    logic                            prg_swap_mode;
    logic [7:0]                      prg_bank_first;
    logic [7:0]                      prg_bank_second;
    logic [CHR_BANKS-1:0][11:0]      chr_bank_regs;
    logic [1:0]                      mirror_reg;
  } bank_state_t;

endpackage

/* design/cbm_regs.sv */
// Bank register file of the cartridge bank mapper: decodes CPU writes and
// holds the PRG, CHR, mirroring and swap registers plus the last bank setting.
// Depends on cbm_pkg.
`timescale 1ns / 1ps

module cbm_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  input  cbm_pkg::req_t       item,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  output cbm_pkg::bank_state_t state,
  output logic [1:0]          mirror_next
);

  cbm_pkg::bank_state_t bank;
  logic [15:0] dec;
  logic [3:0]  page;
  logic [3:0]  page_offset;
  logic [2:0]  chr_index;
  logic        wr_en;
  logic        hit_prg_first;
  logic        hit_mirror;
  logic        hit_swap;
  logic        hit_prg_second;
  logic        hit_chr;

  // Address decode of a CPU write request.
  always_comb begin
    dec            = item.bus_address & cbm_pkg::DECODE_MASK;
    page           = dec[15:12];
    page_offset    = page - cbm_pkg::CHR_PAGE_FIRST;
    chr_index      = {page_offset[1:0], item.bus_address[1]};
    wr_en          = valid && (item.req_type == cbm_pkg::REQ_WRITE);
    hit_prg_first  = wr_en && (dec == cbm_pkg::ADDR_PRG_FIRST);
    hit_mirror     = wr_en && (dec == cbm_pkg::ADDR_MIRROR);
    hit_swap       = wr_en && ((dec == cbm_pkg::ADDR_SWAP_A) ||
                               (dec == cbm_pkg::ADDR_SWAP_B));
    hit_prg_second = wr_en && (dec == cbm_pkg::ADDR_PRG_SECOND);
    hit_chr        = wr_en && (page >= cbm_pkg::CHR_PAGE_FIRST) &&
                     (page <= cbm_pkg::CHR_PAGE_LAST) && (dec[11:6] == 6'd0);
  end

  // Mirroring as it stands once this request has taken effect.
  assign mirror_next = hit_mirror ? item.write_data[1:0] : bank.mirror_reg;
  assign state       = bank;

  // Register updates from configuration and decoded writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      bank.last_prg_bank   <= cbm_pkg::LAST_BANK_RESET;
      bank.prg_swap_mode   <= 1'b0;
      bank.prg_bank_first  <= '0;
      bank.prg_bank_second <= '0;
      bank.chr_bank_regs   <= '0;
      bank.mirror_reg      <= '0;
    end else begin
      if (cfg_we) begin
        bank.last_prg_bank <= cfg_data;
      end
      if (hit_prg_first) begin
        bank.prg_bank_first <= item.write_data;
      end
      if (hit_mirror) begin
        bank.mirror_reg <= item.write_data[1:0];
      end
      if (hit_swap) begin
        bank.prg_swap_mode <= item.write_data[1];
      end
      if (hit_prg_second) begin
        bank.prg_bank_second <= item.write_data;
      end
      if (hit_chr) begin
        if (item.bus_address[0]) begin
          bank.chr_bank_regs[chr_index][11:4] <= item.write_data;
        end else begin
          bank.chr_bank_regs[chr_index][3:0] <= item.write_data[3:0];
        end
      end
    end
  end

  // A mirroring write is visible in the register in the next cycle.
  a_mirror_write: assert property (@(posedge clk) disable iff (rst)
    hit_mirror |=> bank.mirror_reg == $past(item.write_data[1:0]))
    else $error("mirroring register missed a write");

  // Only a write request may change the CHR bank registers.
  a_chr_hold: assert property (@(posedge clk) disable iff (rst)
    !wr_en |=> $stable(bank.chr_bank_regs))
    else $error("CHR bank registers changed without a write request");

  // A configuration write loads the last bank register.
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> bank.last_prg_bank == $past(cfg_data))
    else $error("last bank register missed a configuration write");

endmodule

/* design/cbm_xlate.sv */
// Address translator of the cartridge bank mapper: maps CHR and PRG lookup
// requests onto ROM byte addresses from the current bank registers.
// Depends on cbm_pkg.
`timescale 1ns / 1ps

module cbm_xlate (
  input  cbm_pkg::req_t        item,
  input  cbm_pkg::bank_state_t state,
  output logic [21:0]          rom_address
);

  logic [7:0]  second_last;
  logic [7:0]  prg_bank;
  logic [1:0]  slot;
  logic [2:0]  chr_index;
  logic [21:0] prg_address;
  logic [21:0] chr_address;

  // PRG slot selection; swap mode exchanges the 0x8000 and 0xC000 slots.
  always_comb begin
    second_last = state.last_prg_bank - 8'd1;
    slot        = item.bus_address[14:13];
    case (slot)
      2'd0:    prg_bank = state.prg_swap_mode ? second_last : state.prg_bank_first;
      2'd1:    prg_bank = state.prg_bank_second;
      2'd2:    prg_bank = state.prg_swap_mode ? state.prg_bank_first : second_last;
      default: prg_bank = state.last_prg_bank;
    endcase
    prg_address = {1'b0, prg_bank, item.bus_address[12:0]};
  end

  // CHR lookup through one of the eight 1K bank registers.
  always_comb begin
    chr_index   = item.bus_address[12:10];
    chr_address = {state.chr_bank_regs[chr_index], item.bus_address[9:0]};
  end

  // Writes and the unused request type give a zero address.
  always_comb begin
    case (item.req_type)
      cbm_pkg::REQ_CHR: rom_address = chr_address;
      cbm_pkg::REQ_PRG: rom_address = prg_address;
      default:          rom_address = '0;
    endcase
  end

endmodule

/* design/cartridge_bank_mapper.sv */
// Top level of the cartridge bank mapper: request register, bank register
// file, address translator and result register.
// Depends on cbm_pkg, cbm_regs and cbm_xlate.
`timescale 1ns / 1ps

// The mapper takes one request in every clock cycle; busy is never raised.
// Each request, whether a CPU register write, a CHR lookup or a PRG lookup,
// gives exactly one result: it is held in the request register, where the
// write decode and the translation run, then registered onto the result
// ports with done high for a single cycle. The receiver cannot stall, so it
// must take the result in that cycle. A lookup sees every write accepted
// before it, and mirror_mode shows the mirroring after the request. The user
// must write the last bank setting through cfg_we and cfg_data only while no
// request is in flight; the block itself does not enforce this.
module cartridge_bank_mapper (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  cbm_pkg::req_t     req,
  output logic              done,
  output cbm_pkg::result_t  result,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data
);

  logic                 s1_valid;
  cbm_pkg::req_t        s1_req;
  cbm_pkg::bank_state_t state;
  logic [1:0]           mirror_next;
  logic [21:0]          rom_address;

  assign busy = 1'b0;

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_req <= req;
  end

  cbm_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .valid      (s1_valid),
    .item       (s1_req),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .state      (state),
    .mirror_next(mirror_next)
  );

  cbm_xlate u_xlate (
    .item       (s1_req),
    .state      (state),
    .rom_address(rom_address)
  );

  // Result register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
    result.rom_address <= rom_address;
    result.mirror_mode <= mirror_next;
  end

  // Every result traces back to a request that passed through the request register and the result register.
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 2))
    else $error("result without a matching request");

  // Write requests and the unused type report a zero ROM address.
  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1_req.req_type != cbm_pkg::REQ_CHR) &&
     (s1_req.req_type != cbm_pkg::REQ_PRG)) |=> result.rom_address == '0)
    else $error("nonzero ROM address for a non-lookup request");

  // The 0xE000 slot always maps to the last PRG bank.
  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1_req.req_type == cbm_pkg::REQ_PRG) &&
     (s1_req.bus_address[14:13] == 2'b11))
    |=> result.rom_address[20:13] == $past(state.last_prg_bank))
    else $error("top PRG slot not mapped to the last bank");

endmodule
